@@ hw/rtl/cpam_pkg.sv @@
// shared constants, types and saturation helper for the attitude controller
package cpam_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int SCALE_FRAC = 16;
  localparam int SAT_W      = 64;

  // integration window tolerance, 0.00001 in data format rounded to nearest
  localparam logic signed [SAT_W-1:0] EPS_FIX =
    SAT_W'(((64'sd1 << FRAC_BITS) + 64'sd50000) / 64'sd100000);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_OUTER_GAIN_PITCH = 3'd0;
  localparam logic [2:0] REG_OUTER_GAIN_ROLL  = 3'd1;
  localparam logic [2:0] REG_OUTER_GAIN_YAW   = 3'd2;
  localparam logic [2:0] REG_RATE_PROP_GAIN   = 3'd3;
  localparam logic [2:0] REG_RATE_INTEG_GAIN  = 3'd4;
  localparam logic [2:0] REG_RATE_DERIV_GAIN  = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_LIMIT   = 3'd6;
  localparam logic [2:0] REG_OUTPUT_SCALE     = 3'd7;

  localparam logic [15:0] RST_OUTER_GAIN_PITCH = 16'd2867;
  localparam logic [15:0] RST_OUTER_GAIN_ROLL  = 16'd410;
  localparam logic [15:0] RST_OUTER_GAIN_YAW   = 16'd2867;
  localparam logic [15:0] RST_RATE_PROP_GAIN   = 16'd2867;
  localparam logic [15:0] RST_RATE_INTEG_GAIN  = 16'd410;
  localparam logic [15:0] RST_RATE_DERIV_GAIN  = 16'd41;
  localparam logic [30:0] RST_INTEGRAL_LIMIT   = 31'd655360;
  localparam logic [15:0] RST_OUTPUT_SCALE     = 16'd3557;

  typedef struct packed {
    logic commit;
  } cpam_lane_ctrl_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [30:0] limit;
  } cpam_inner_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cpam_axis.sv @@
// one axis lane: outer angle p loop and inner rate pid with its own state
module cpam_axis (
  input  logic                          clk,
  input  logic                          rst,
  input  cpam_pkg::cpam_lane_ctrl_t     ctrl,
  input  cpam_pkg::cpam_inner_cfg_t     inner,
  input  logic                   [15:0] outer_gain,
  input  logic signed            [31:0] rate,
  input  logic signed            [31:0] angle,
  input  logic signed            [31:0] target,
  output logic signed            [31:0] axis_out
);

  logic signed [31:0] err;
  logic signed [48:0] prod;
  logic signed [31:0] sp;
  logic signed [31:0] e;
  logic               win;
  logic signed [31:0] d_c;
  logic signed [31:0] integral_sum;
  logic signed [31:0] prev_rate_error;
  logic signed [48:0] prod_p;
  logic signed [48:0] prod_i;
  logic signed [48:0] prod_d;
  logic signed [50:0] acc;

  logic signed [16:0] outer_s;
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [63:0] lim_s;
  logic signed [63:0] sum_s;
  logic signed [48:0] prod_rnd;
  logic signed [50:0] acc_rnd;

  assign outer_s  = {1'b0, outer_gain};
  assign kp_s     = {1'b0, inner.kp};
  assign ki_s     = {1'b0, inner.ki};
  assign kd_s     = {1'b0, inner.kd};
  assign lim_s    = {33'd0, inner.limit};
  assign sum_s    = 64'(integral_sum);
  assign prod_rnd = (prod + 49'sd2048) >>> cpam_pkg::GAIN_FRAC;
  assign acc_rnd  = (acc + 51'sd2048) >>> cpam_pkg::GAIN_FRAC;

  // angle loop and rate error, recomputed every cycle from the held sample
  always_ff @(posedge clk) begin
    err  <= cpam_pkg::sat32(64'(target) - 64'(angle));
    prod <= 49'(err) * 49'(outer_s);
    sp   <= cpam_pkg::sat32(64'(prod_rnd));
    e    <= cpam_pkg::sat32(64'(sp) - 64'(rate));
    win  <= ((sum_s - lim_s) <= cpam_pkg::EPS_FIX) && ((sum_s + lim_s) >= cpam_pkg::EPS_FIX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum    <= '0;
      prev_rate_error <= '0;
    end else if (ctrl.commit) begin
      if (win) begin
        integral_sum <= cpam_pkg::sat32(sum_s + 64'(e));
      end
      prev_rate_error <= e;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      d_c <= cpam_pkg::sat32(64'(e) - 64'(prev_rate_error));
    end
  end

  // after commit the state holds this sample's error and integral
  always_ff @(posedge clk) begin
    prod_p   <= 49'(kp_s) * 49'(prev_rate_error);
    prod_i   <= 49'(ki_s) * 49'(integral_sum);
    prod_d   <= 49'(kd_s) * 49'(d_c);
    acc      <= 51'(prod_p) + 51'(prod_i) + 51'(prod_d);
    axis_out <= cpam_pkg::sat32(64'(acc_rnd));
  end

endmodule

@@ hw/rtl/cpam_mixer.sv @@
// motor mixer: combines the three axis outputs and throttle into four commands
module cpam_mixer (
  input  logic               clk,
  input  logic signed [31:0] roll,
  input  logic signed [31:0] pitch,
  input  logic signed [31:0] yaw,
  input  logic signed [31:0] throttle,
  input  logic        [15:0] scale,
  output logic signed [31:0] motor_one,
  output logic signed [31:0] motor_two,
  output logic signed [31:0] motor_three,
  output logic signed [31:0] motor_four
);

  logic signed [33:0] mix_sum [4];
  logic signed [50:0] mix_prod [4];
  logic signed [50:0] mix_rnd [4];
  logic signed [33:0] r_w;
  logic signed [33:0] p_w;
  logic signed [33:0] y_w;
  logic signed [33:0] t_w;
  logic signed [16:0] scale_s;

  assign r_w     = 34'(roll);
  assign p_w     = 34'(pitch);
  assign y_w     = 34'(yaw);
  assign t_w     = 34'(throttle);
  assign scale_s = {1'b0, scale};

  always_ff @(posedge clk) begin
    mix_sum[0] <= -r_w + p_w + y_w + t_w;
    mix_sum[1] <=  r_w + p_w - y_w + t_w;
    mix_sum[2] <= -r_w - p_w + y_w + t_w;
    mix_sum[3] <=  r_w - p_w - y_w + t_w;
    for (int i = 0; i < 4; i++) begin
      mix_prod[i] <= 51'(mix_sum[i]) * 51'(scale_s);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mix_rnd[i] = (mix_prod[i] + 51'sd32768) >>> cpam_pkg::SCALE_FRAC;
    end
  end

  // commands are negated after rounding
  assign motor_one   = cpam_pkg::sat32(-64'(mix_rnd[0]));
  assign motor_two   = cpam_pkg::sat32(-64'(mix_rnd[1]));
  assign motor_three = cpam_pkg::sat32(-64'(mix_rnd[2]));
  assign motor_four  = cpam_pkg::sat32(-64'(mix_rnd[3]));

endmodule

@@ hw/rtl/cascade_pid_attitude_mixer_top.sv @@
// top level: register file, sample sequencing, three axis lanes and the mixer
// Cascaded attitude controller with quadcopter mixer. One sample (rates,
// angles, targets, throttle; Q16.16) is taken at a time and gives one set of
// four motor commands; a new sample is taken only after the result has
// reached the output register, which waits while the output is stalled, so
// the block never takes a new sample before the last one is through. The
// result passes through each axis lane (gain multiply, rounding, rate
// error, integral and derivative update, three PID products and their sum)
// followed by the two mixer stages. Roll, pitch and yaw run in parallel lanes,
// each keeping its own integral and previous rate error; the integral stops
// changing once it has left the window set by integral_limit. Registers sit
// on a 32-bit APB-style port at byte address 4 times their index.
module cascade_pid_attitude_mixer_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [cpam_pkg::ADDR_W-1:0]    paddr,
  input  logic        [cpam_pkg::DATA_W-1:0]    pwdata,
  output logic        [cpam_pkg::DATA_W-1:0]    prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [31:0]                    rate_roll,
  input  logic signed [31:0]                    rate_pitch,
  input  logic signed [31:0]                    rate_yaw,
  input  logic signed [31:0]                    angle_roll,
  input  logic signed [31:0]                    angle_pitch,
  input  logic signed [31:0]                    angle_yaw,
  input  logic signed [31:0]                    target_roll,
  input  logic signed [31:0]                    target_pitch,
  input  logic signed [31:0]                    target_yaw,
  input  logic signed [31:0]                    throttle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    motor_one,
  output logic signed [31:0]                    motor_two,
  output logic signed [31:0]                    motor_three,
  output logic signed [31:0]                    motor_four
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [3:0] STEP_COMMIT = 4'd4;
  localparam logic [3:0] STEP_LAST   = 4'd10;

  logic [15:0] outer_gain_pitch;
  logic [15:0] outer_gain_roll;
  logic [15:0] outer_gain_yaw;
  logic [15:0] rate_prop_gain;
  logic [15:0] rate_integ_gain;
  logic [15:0] rate_deriv_gain;
  logic [30:0] integral_limit;
  logic [15:0] output_scale;

  logic [1:0] state;
  logic [3:0] step;

  logic signed [31:0] smp_rate_roll;
  logic signed [31:0] smp_rate_pitch;
  logic signed [31:0] smp_rate_yaw;
  logic signed [31:0] smp_angle_roll;
  logic signed [31:0] smp_angle_pitch;
  logic signed [31:0] smp_angle_yaw;
  logic signed [31:0] smp_target_roll;
  logic signed [31:0] smp_target_pitch;
  logic signed [31:0] smp_target_yaw;
  logic signed [31:0] smp_throttle;

  logic signed [31:0] u_roll;
  logic signed [31:0] u_pitch;
  logic signed [31:0] u_yaw;
  logic signed [31:0] mix_one;
  logic signed [31:0] mix_two;
  logic signed [31:0] mix_three;
  logic signed [31:0] mix_four;

  cpam_pkg::cpam_lane_ctrl_t lane_ctrl;
  cpam_pkg::cpam_inner_cfg_t inner;

  logic cfg_wr;
  logic in_take;
  logic out_free;
  logic out_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free &&
                    (((state == ST_RUN) && (step == STEP_LAST)) || (state == ST_HOLD));

  assign lane_ctrl.commit = (state == ST_RUN) && (step == STEP_COMMIT);
  assign inner.kp    = rate_prop_gain;
  assign inner.ki    = rate_integ_gain;
  assign inner.kd    = rate_deriv_gain;
  assign inner.limit = integral_limit;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_gain_pitch <= cpam_pkg::RST_OUTER_GAIN_PITCH;
      outer_gain_roll  <= cpam_pkg::RST_OUTER_GAIN_ROLL;
      outer_gain_yaw   <= cpam_pkg::RST_OUTER_GAIN_YAW;
      rate_prop_gain   <= cpam_pkg::RST_RATE_PROP_GAIN;
      rate_integ_gain  <= cpam_pkg::RST_RATE_INTEG_GAIN;
      rate_deriv_gain  <= cpam_pkg::RST_RATE_DERIV_GAIN;
      integral_limit   <= cpam_pkg::RST_INTEGRAL_LIMIT;
      output_scale     <= cpam_pkg::RST_OUTPUT_SCALE;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        cpam_pkg::REG_OUTER_GAIN_PITCH: outer_gain_pitch <= pwdata[15:0];
        cpam_pkg::REG_OUTER_GAIN_ROLL:  outer_gain_roll  <= pwdata[15:0];
        cpam_pkg::REG_OUTER_GAIN_YAW:   outer_gain_yaw   <= pwdata[15:0];
        cpam_pkg::REG_RATE_PROP_GAIN:   rate_prop_gain   <= pwdata[15:0];
        cpam_pkg::REG_RATE_INTEG_GAIN:  rate_integ_gain  <= pwdata[15:0];
        cpam_pkg::REG_RATE_DERIV_GAIN:  rate_deriv_gain  <= pwdata[15:0];
        cpam_pkg::REG_INTEGRAL_LIMIT:   integral_limit   <= pwdata[30:0];
        cpam_pkg::REG_OUTPUT_SCALE:     output_scale     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      cpam_pkg::REG_OUTER_GAIN_PITCH: prdata = {16'd0, outer_gain_pitch};
      cpam_pkg::REG_OUTER_GAIN_ROLL:  prdata = {16'd0, outer_gain_roll};
      cpam_pkg::REG_OUTER_GAIN_YAW:   prdata = {16'd0, outer_gain_yaw};
      cpam_pkg::REG_RATE_PROP_GAIN:   prdata = {16'd0, rate_prop_gain};
      cpam_pkg::REG_RATE_INTEG_GAIN:  prdata = {16'd0, rate_integ_gain};
      cpam_pkg::REG_RATE_DERIV_GAIN:  prdata = {16'd0, rate_deriv_gain};
      cpam_pkg::REG_INTEGRAL_LIMIT:   prdata = {1'b0, integral_limit};
      cpam_pkg::REG_OUTPUT_SCALE:     prdata = {16'd0, output_scale};
      default:                        prdata = '0;
    endcase
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_rate_roll    <= rate_roll;
      smp_rate_pitch   <= rate_pitch;
      smp_rate_yaw     <= rate_yaw;
      smp_angle_roll   <= angle_roll;
      smp_angle_pitch  <= angle_pitch;
      smp_angle_yaw    <= angle_yaw;
      smp_target_roll  <= target_roll;
      smp_target_pitch <= target_pitch;
      smp_target_yaw   <= target_yaw;
      smp_throttle     <= throttle;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step == STEP_LAST) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      motor_one   <= mix_one;
      motor_two   <= mix_two;
      motor_three <= mix_three;
      motor_four  <= mix_four;
    end
  end

  cpam_axis u_axis_roll (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .inner      (inner),
    .outer_gain (outer_gain_roll),
    .rate       (smp_rate_roll),
    .angle      (smp_angle_roll),
    .target     (smp_target_roll),
    .axis_out   (u_roll)
  );

  cpam_axis u_axis_pitch (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .inner      (inner),
    .outer_gain (outer_gain_pitch),
    .rate       (smp_rate_pitch),
    .angle      (smp_angle_pitch),
    .target     (smp_target_pitch),
    .axis_out   (u_pitch)
  );

  cpam_axis u_axis_yaw (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .inner      (inner),
    .outer_gain (outer_gain_yaw),
    .rate       (smp_rate_yaw),
    .angle      (smp_angle_yaw),
    .target     (smp_target_yaw),
    .axis_out   (u_yaw)
  );

  cpam_mixer u_mixer (
    .clk         (clk),
    .roll        (u_roll),
    .pitch       (u_pitch),
    .yaw         (u_yaw),
    .throttle    (smp_throttle),
    .scale       (output_scale),
    .motor_one   (mix_one),
    .motor_two   (mix_two),
    .motor_three (mix_three),
    .motor_four  (mix_four)
  );

  // a transaction taken starts the lanes from the first step
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_RUN) && (step == '0))
    else $error("accepted sample did not start the sequencer");

  // waiting for the output only while a result still occupies it
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("hold state with an empty output register");

  // a new result only appears at the end of a run or from hold
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RUN) || ($past(state) == ST_HOLD))
    else $error("result presented without a finished sample");

  // lane state updated only during a run
  a_commit_in_run: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.commit |-> (state == ST_RUN) && !in_stall == 1'b0)
    else $error("lane state updated outside a run");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= STEP_LAST))
    else $error("sequencer step out of range");

endmodule
